[design/ukst_pkg.sv]
// ----------------------------------------------------------------------------
// ukst_pkg
// Shared types and codes of the unique key set table.
// ----------------------------------------------------------------------------
package ukst_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned KeyBitsDef  = 32;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned StatW  = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_SEARCH = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE   = 2'd0,
    ST_NOCHG  = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [KeyW-1:0]  key;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
    logic [StatW-1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic occ;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

[design/ukst_cell.sv]
// ----------------------------------------------------------------------------
// ukst_cell
// One slot of the table: holds a key, compares it and takes its neighbour's.
// ----------------------------------------------------------------------------
module ukst_cell #(
  parameter int unsigned KeyBits = ukst_pkg::KeyBitsDef
) (
  input  logic                clk_i,
  input  ukst_pkg::cell_ctl_t ctl_i,
  input  logic [KeyBits-1:0]  key_i,
  input  logic [KeyBits-1:0]  nbr_key_i,
  output logic [KeyBits-1:0]  key_o,
  output logic                match_o
);

  logic [KeyBits-1:0] key_q, key_d;
  logic               match_q, match_d;

  always_comb begin
    key_d = key_q;
    if (ctl_i.load) begin
      key_d = key_i;
    end else if (ctl_i.shift) begin
      key_d = nbr_key_i;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctl_i.cmp) begin
      match_d = ctl_i.occ && (key_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    match_q <= match_d;
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule

[design/unique_key_set_table.sv]
// ----------------------------------------------------------------------------
// unique_key_set_table
// Packed set of distinct keys in insertion order: search, add, remove.
// ----------------------------------------------------------------------------
// For each request, in the cycle of start every slot
// compares its key with the request key and registers the match; in the next
// cycle busy is high, the single match is encoded to a position and an add
// writes the slot at the fill count or a remove moves every later slot down
// one place. The result is shown on rsp_o for one cycle with done_o high and
// cannot be held off; a new start is taken in that same cycle. Slot contents
// need no clearing after reset, the fill count alone marks what is stored.
module unique_key_set_table #(
  parameter int unsigned Capacity = ukst_pkg::CapacityDef,
  parameter int unsigned KeyBits  = ukst_pkg::KeyBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ukst_pkg::req_t req_i,
  output logic           done_o,
  output ukst_pkg::rsp_t rsp_o
);

  localparam int unsigned PW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned KeyW64 = ukst_pkg::KeyW + KeyBits;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]      count_q, count_d;
  logic [KeyBits-1:0] key_q;
  logic [ukst_pkg::FuncW-1:0] func_q;
  logic               done_q, done_d;
  ukst_pkg::rsp_t     rsp_q, rsp_d;

  logic [KeyBits-1:0] req_key;
  logic [KeyBits-1:0] cell_key_in;
  logic [KeyW64-1:0]  key_ext;

  logic                accept;
  logic                exec;
  logic [Capacity-1:0] match;
  logic                hit;
  logic [PW-1:0]       pos;
  logic                full;
  logic                do_add;
  logic                do_rem;
  logic [Capacity-1:0][KeyBits-1:0] cell_key;
  ukst_pkg::cell_ctl_t [Capacity-1:0] ctl;
  logic [PW+ukst_pkg::PosW-1:0]   pos_ext;
  logic [CW+ukst_pkg::CountW-1:0] cnt_ext;

  assign accept  = start && !busy;
  assign exec    = (state_q == S_EXEC);
  assign busy    = exec;
  assign key_ext = {{KeyBits{1'b0}}, req_i.key};
  assign req_key = key_ext[KeyBits-1:0];

  // the compare uses the request key, the load uses the held key
  assign cell_key_in = exec ? key_q : req_key;

  always_comb begin
    pos = '0;
    for (int i = 0; i < Capacity; i++) begin
      pos = pos | (match[i] ? PW'(i) : PW'(0));
    end
  end

  assign hit  = |match;
  assign full = (count_q == CW'(Capacity));
  assign do_add = exec && (func_q == ukst_pkg::FUNC_ADD) && !hit && !full;
  assign do_rem = exec && (func_q == ukst_pkg::FUNC_REMOVE) && hit;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    localparam logic [CW-1:0] Idx  = CW'(i);
    localparam logic [CW-1:0] Idx1 = CW'(i + 1);

    assign ctl[i].cmp   = accept;
    assign ctl[i].occ   = (Idx < count_q);
    assign ctl[i].load  = do_add && (Idx == count_q);
    assign ctl[i].shift = do_rem && (Idx >= CW'(pos)) && (Idx1 < count_q);

    if (i == Capacity - 1) begin : g_last
      ukst_cell #(.KeyBits(KeyBits)) u_cell (
        .clk_i    (clk_i),
        .ctl_i    (ctl[i]),
        .key_i    (cell_key_in),
        .nbr_key_i({KeyBits{1'b0}}),
        .key_o    (cell_key[i]),
        .match_o  (match[i])
      );
    end else begin : g_mid
      ukst_cell #(.KeyBits(KeyBits)) u_cell (
        .clk_i    (clk_i),
        .ctl_i    (ctl[i]),
        .key_i    (cell_key_in),
        .nbr_key_i(cell_key[i+1]),
        .key_o    (cell_key[i]),
        .match_o  (match[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_add) begin
      count_d = count_q + CW'(1);
    end else if (do_rem) begin
      count_d = count_q - CW'(1);
    end
  end

  assign pos_ext = {{ukst_pkg::PosW{1'b0}}, pos};
  assign cnt_ext = {{ukst_pkg::CountW{1'b0}}, count_d};

  always_comb begin
    rsp_d          = rsp_q;
    rsp_d.found    = hit;
    rsp_d.position = pos_ext[ukst_pkg::PosW-1:0];
    rsp_d.count    = cnt_ext[ukst_pkg::CountW-1:0];
    unique case (func_q)
      ukst_pkg::FUNC_ADD: begin
        if (hit) begin
          rsp_d.status = ukst_pkg::ST_NOCHG;
        end else if (full) begin
          rsp_d.status = ukst_pkg::ST_FULL;
        end else begin
          rsp_d.status = ukst_pkg::ST_DONE;
        end
      end
      default: begin
        rsp_d.status = hit ? ukst_pkg::ST_DONE : ukst_pkg::ST_NOCHG;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= req_key;
      func_q <= req_i.func;
    end
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[design/ukst_chk.sv]
// ----------------------------------------------------------------------------
// ukst_chk
// Port-level checks of the unique key set table, bound to the top level.
// ----------------------------------------------------------------------------
module ukst_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input ukst_pkg::req_t req_i,
  input logic           done_o,
  input ukst_pkg::rsp_t rsp_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> !$isunknown(req_i) ##1 busy)
    else $error("accepted beat unknown or did not raise busy");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("result beat missing after busy cycle");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a request");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.found |-> rsp_o.position == '0)
    else $error("position set on a miss");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ukst_pkg::ST_FULL |-> !rsp_o.found)
    else $error("refused add reported a hit");

endmodule

bind unique_key_set_table ukst_chk u_ukst_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

[dv/unique_key_set_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unique_key_set_table_tb
// Self-checking bench for the unique key set table.
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge and taken when start is high and
// busy is low. A behavioural copy of the key set works out each response as
// its request is taken and queues it. Every done_o beat is checked field by
// field against the oldest queued response. Stimulus runs from a short
// directed sequence, through filling and draining the store, to random
// traffic over a small key pool with and without gaps between requests.
// ----------------------------------------------------------------------------
module unique_key_set_table_tb;

  localparam int unsigned Capacity = ukst_pkg::CapacityDef;
  localparam int unsigned KeyBits  = ukst_pkg::KeyBitsDef;
  localparam int unsigned KeyW     = ukst_pkg::KeyW;
  localparam int unsigned FuncW    = ukst_pkg::FuncW;
  localparam int unsigned PosW     = ukst_pkg::PosW;
  localparam int unsigned CountW   = ukst_pkg::CountW;
  localparam logic [KeyW-1:0] KeyMask =
      (KeyBits >= KeyW) ? {KeyW{1'b1}} : ((KeyW'(1) << KeyBits) - 1'b1);
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam int unsigned PoolSize = 80;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  ukst_pkg::req_t  req_i;
  logic            done_o;
  ukst_pkg::rsp_t  rsp_o;

  logic [KeyW-1:0] set_keys [Capacity];
  int unsigned     set_count;
  ukst_pkg::rsp_t  pending_rsp_q [$];
  ukst_pkg::rsp_t  expected_rsp;
  int unsigned     errors;
  int unsigned     idle_pct;
  logic [KeyW-1:0] key_pool [PoolSize];

  unique_key_set_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // applies one request to the key set and returns the response it gives
  function automatic ukst_pkg::rsp_t apply_to_key_set(ukst_pkg::req_t r);
    logic [KeyW-1:0]   k;
    int                hit_idx;
    ukst_pkg::status_e st;
    ukst_pkg::rsp_t    rsp;
    k = r.key & KeyMask;
    hit_idx = -1;
    for (int i = 0; i < int'(set_count); i++) begin
      if (hit_idx < 0 && set_keys[i] == k) hit_idx = i;
    end
    case (r.func)
      ukst_pkg::FUNC_ADD: begin
        if (hit_idx >= 0) begin
          st = ukst_pkg::ST_NOCHG;
        end else if (set_count >= Capacity) begin
          st = ukst_pkg::ST_FULL;
        end else begin
          set_keys[set_count] = k;
          set_count++;
          st = ukst_pkg::ST_DONE;
        end
      end
      ukst_pkg::FUNC_REMOVE: begin
        if (hit_idx >= 0) begin
          for (int i = hit_idx; i + 1 < int'(set_count); i++) set_keys[i] = set_keys[i+1];
          set_count--;
          st = ukst_pkg::ST_DONE;
        end else begin
          st = ukst_pkg::ST_NOCHG;
        end
      end
      default: begin
        st = (hit_idx >= 0) ? ukst_pkg::ST_DONE : ukst_pkg::ST_NOCHG;
      end
    endcase
    rsp.found    = (hit_idx >= 0);
    rsp.position = (hit_idx >= 0) ? PosW'(hit_idx) : '0;
    rsp.count    = CountW'(set_count);
    rsp.status   = st;
    return rsp;
  endfunction

  // one request beat, with a random gap ahead of it
  task automatic send_req(input logic [FuncW-1:0] f, input logic [KeyW-1:0] k);
    int unsigned    gap;
    ukst_pkg::req_t r;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      r.func = FuncW'($urandom);
      r.key  = $urandom;
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= r;
      repeat (gap - 1) @(negedge clk_i);
    end
    r.func = f;
    r.key  = k;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_rsp_q.push_back(apply_to_key_set(r));
  endtask

  task automatic wait_drained();
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_req(ukst_pkg::FUNC_SEARCH, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_REMOVE, 32'hFFFF_FFFF);
    send_req(FuncUnused, 32'h1234_5678);
    send_req(ukst_pkg::FUNC_ADD, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_ADD, 32'hFFFF_FFFF);
    send_req(ukst_pkg::FUNC_ADD, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_ADD, 32'h8000_0001);
    send_req(ukst_pkg::FUNC_ADD, 32'h7FFF_FFFE);
    send_req(ukst_pkg::FUNC_SEARCH, 32'hFFFF_FFFF);
    send_req(FuncUnused, 32'h7FFF_FFFE);
    send_req(FuncUnused, 32'h5555_AAAA);
    send_req(ukst_pkg::FUNC_SEARCH, 32'hAAAA_5555);
    send_req(ukst_pkg::FUNC_REMOVE, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_SEARCH, 32'h8000_0001);
    send_req(ukst_pkg::FUNC_REMOVE, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_REMOVE, 32'h7FFF_FFFE);
    send_req(ukst_pkg::FUNC_ADD, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_SEARCH, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_REMOVE, 32'hFFFF_FFFF);
    send_req(ukst_pkg::FUNC_REMOVE, 32'h8000_0001);
    send_req(ukst_pkg::FUNC_REMOVE, 32'h0000_0000);
    send_req(ukst_pkg::FUNC_SEARCH, 32'h0000_0000);
  endtask

  // fill to capacity, knock on the full store, then drain in random order
  task automatic test_fill_and_drain();
    logic [KeyW-1:0] base;
    base = $urandom;
    for (int i = 0; i < int'(Capacity); i++) begin
      send_req(ukst_pkg::FUNC_ADD, base + i * 32'h9E37_79B9);
    end
    send_req(ukst_pkg::FUNC_ADD, base + Capacity * 32'h9E37_79B9);
    send_req(ukst_pkg::FUNC_ADD, set_keys[Capacity-1]);
    send_req(ukst_pkg::FUNC_SEARCH, set_keys[Capacity-1]);
    send_req(ukst_pkg::FUNC_REMOVE, set_keys[0]);
    send_req(ukst_pkg::FUNC_SEARCH, set_keys[Capacity-2]);
    send_req(ukst_pkg::FUNC_ADD, ~base);
    send_req(ukst_pkg::FUNC_ADD, base ^ 32'h0F0F_0F0F);
    while (set_count > 0) begin
      send_req(ukst_pkg::FUNC_REMOVE, set_keys[$urandom_range(set_count - 1)]);
    end
    send_req(ukst_pkg::FUNC_REMOVE, base);
  endtask

  // random traffic over a key pool a little larger than the store
  task automatic test_random(input int unsigned n_items, input int unsigned add_pct);
    int unsigned      pick;
    logic [FuncW-1:0] f;
    logic [KeyW-1:0]  k;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < add_pct) f = ukst_pkg::FUNC_ADD;
      else if (pick < add_pct + (100 - add_pct) * 2 / 3) f = ukst_pkg::FUNC_REMOVE;
      else if (pick < 96) f = ukst_pkg::FUNC_SEARCH;
      else f = FuncUnused;
      if ($urandom_range(99) < 12) k = $urandom;
      else if (set_count > 0 && f == ukst_pkg::FUNC_REMOVE && $urandom_range(1) == 1)
        k = set_keys[$urandom_range(set_count - 1)];
      else k = key_pool[$urandom_range(PoolSize - 1)];
      send_req(f, k);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response beat with no request pending");
        errors++;
      end else begin
        expected_rsp = pending_rsp_q.pop_front();
        if (rsp_o.found !== expected_rsp.found) begin
          $error("found: expected %0d, got %0d", expected_rsp.found, rsp_o.found);
          errors++;
        end
        if (rsp_o.position !== expected_rsp.position) begin
          $error("position: expected %0d, got %0d", expected_rsp.position, rsp_o.position);
          errors++;
        end
        if (rsp_o.count !== expected_rsp.count) begin
          $error("count: expected %0d, got %0d", expected_rsp.count, rsp_o.count);
          errors++;
        end
        if (rsp_o.status !== expected_rsp.status) begin
          $error("status: expected %0d, got %0d", expected_rsp.status, rsp_o.status);
          errors++;
        end
      end
    end
  end

  initial begin
    errors    = 0;
    idle_pct  = 0;
    set_count = 0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    req_i     = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_fill_and_drain();
    test_random(350, 55);
    idle_pct = 70;
    test_random(300, 45);
    idle_pct = 27;
    test_random(350, 60);
    idle_pct = 0;
    test_random(200, 35);

    @(negedge clk_i);
    start <= 1'b0;
    wait_drained();
    if (pending_rsp_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
